FILE: design/nsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types and constants for the per-channel energy seizure detector.
// ----------------------------------------------------------------------------
package nsd_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 64;
  localparam int unsigned MAX_CHANNELS     = 64;   // reach of the channel field

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned CHAN_W  = 6;
  localparam int unsigned IDX_W   = 48;
  localparam int unsigned THR_W   = 32;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned ONS_W   = 8;
  localparam int unsigned FILL_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [FILL_W-1:0] NEEDED_CODES = 2'd3;

  localparam logic [THR_W-1:0] THR_RESET = 32'd1000000;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd1000;
  localparam logic [ONS_W-1:0] ONS_RESET = 8'd3;

  // configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONSET     = 2'd2;

  // event kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] older;
    logic [CODE_W-1:0] newer;
    logic [FILL_W-1:0] fill;
    logic              seizure;
    logic [ONS_W-1:0]  hit_run;
    logic [TMO_W-1:0]  miss_run;
  } chan_state_t;

  localparam int unsigned STATE_W = $bits(chan_state_t);

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [IDX_W-1:0] sample;
  } event_t;

endpackage

FILE: design/nsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // a read at the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/nsd_energy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_energy
// Absolute Teager-Kaiser energy of three codes and threshold compare.
// ----------------------------------------------------------------------------
module nsd_energy
  import nsd_pkg::*;
(
  input  logic [CODE_W-1:0] prev_i,
  input  logic [CODE_W-1:0] cur_i,
  input  logic [CODE_W-1:0] next_i,
  input  logic [THR_W-1:0]  threshold_i,
  output logic              hit_o
);

  logic signed [CODE_W-1:0]   pa, pb, pc;
  logic signed [2*CODE_W-1:0] sq, pr;
  logic signed [2*CODE_W:0]   diff;
  logic        [2*CODE_W:0]   mag;

  // subtracting midscale is a flip of the top bit
  assign pa = {~prev_i[CODE_W-1], prev_i[CODE_W-2:0]};
  assign pb = {~cur_i[CODE_W-1],  cur_i[CODE_W-2:0]};
  assign pc = {~next_i[CODE_W-1], next_i[CODE_W-2:0]};

  assign sq   = pb * pb;
  assign pr   = pa * pc;
  assign diff = (2*CODE_W+1)'(sq) - (2*CODE_W+1)'(pr);
  assign mag  = diff[2*CODE_W] ? (2*CODE_W+1)'(-diff) : (2*CODE_W+1)'(diff);

  assign hit_o = mag > {1'b0, threshold_i};

endmodule

FILE: design/nsd_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_track
// Per-channel history shift, onset and quiet counters, event generation.
// ----------------------------------------------------------------------------
module nsd_track
  import nsd_pkg::*;
(
  input  chan_state_t       state_i,
  input  logic [CODE_W-1:0] code_i,
  input  logic [IDX_W-1:0]  sample_number_i,
  input  logic              hit_i,
  input  logic [TMO_W-1:0]  timeout_i,
  input  logic [ONS_W-1:0]  onset_i,
  output chan_state_t       state_o,
  output event_t            event_o
);

  logic [ONS_W-1:0]  onset_eff;
  logic [FILL_W-1:0] fill_n;
  logic [ONS_W:0]    hit_inc;
  logic [TMO_W:0]    miss_inc;

  assign onset_eff = (onset_i == '0) ? ONS_W'(1) : onset_i;
  assign fill_n    = (state_i.fill == NEEDED_CODES) ? state_i.fill
                                                    : state_i.fill + FILL_W'(1);
  assign hit_inc   = {1'b0, state_i.hit_run} + (ONS_W+1)'(1);
  assign miss_inc  = {1'b0, state_i.miss_run} + (TMO_W+1)'(1);

  always_comb begin
    state_o        = state_i;
    state_o.older  = state_i.newer;
    state_o.newer  = code_i;
    state_o.fill   = fill_n;
    event_o        = '0;
    event_o.kind   = KIND_START;
    event_o.sample = sample_number_i;
    if (fill_n == NEEDED_CODES) begin
      if (!state_i.seizure) begin
        if (!hit_i) begin
          state_o.hit_run = '0;
        end else begin
          state_o.miss_run = '0;
          if (hit_inc >= {1'b0, onset_eff}) begin
            state_o.hit_run = '0;
            state_o.seizure = 1'b1;
            event_o.valid   = 1'b1;
            event_o.kind    = KIND_START;
            event_o.sample  = sample_number_i
                              - {(IDX_W-ONS_W)'(0), onset_eff - ONS_W'(1)};
          end else begin
            state_o.hit_run = hit_inc[ONS_W-1:0];
          end
        end
      end else begin
        if (hit_i) begin
          state_o.miss_run = '0;
        end else if (miss_inc >= {1'b0, timeout_i}) begin
          state_o.miss_run = '0;
          state_o.seizure  = 1'b0;
          event_o.valid    = 1'b1;
          event_o.kind     = KIND_END;
          event_o.sample   = sample_number_i - {(IDX_W-TMO_W)'(0), timeout_i};
        end else begin
          state_o.miss_run = miss_inc[TMO_W-1:0];
        end
      end
    end
  end

endmodule

FILE: design/neo_seizure_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neo_seizure_detector
// Multichannel nonlinear-energy seizure onset and end detector.
// ----------------------------------------------------------------------------
// Pipeline: stage 1 registers each beat and its state read, the output its
// event. Throughput: one sample per cycle unless the receiver stalls, set by
// the state RAM read-modify-write, with the just-written word forwarded on a
// repeat. Reset: asynchronous; per-channel valid flops, counters and
// configuration return to their defaults at once, no clearing pass is needed.
// ----------------------------------------------------------------------------
module neo_seizure_detector
  import nsd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CODE_W-1:0]     adc_sample_i,
  input  logic [CHAN_W-1:0]     channel_i,
  input  logic [IDX_W-1:0]      sample_number_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  event_kind_o,
  output logic [CHAN_W-1:0]     event_channel_o,
  output logic [IDX_W-1:0]      event_sample_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = (NUM_CHANNELS < MAX_CHANNELS) ? NUM_CHANNELS
                                                                : MAX_CHANNELS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [THR_W-1:0] thr_q;
  logic [TMO_W-1:0] tmo_q;
  logic [ONS_W-1:0] ons_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      tmo_q <= TMO_RESET;
      ons_q <= ONS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
        CFG_TIMEOUT:   tmo_q <= cfg_data_i[TMO_W-1:0];
        CFG_ONSET:     ons_q <= cfg_data_i[ONS_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q, s1_valid_d;
  logic s1_adv, in_fire, in_range;
  logic out_valid_q, out_valid_d;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = 32'(channel_i) < NUM_CHANNELS;

  // stage 1 payload
  logic [CODE_W-1:0] code_q;
  logic [CHAN_W-1:0] chan_q;
  logic [IDX_W-1:0]  idx_q;
  logic [AW-1:0]     rd_addr, s1_addr;

  assign rd_addr = channel_i[AW-1:0];
  assign s1_addr = chan_q[AW-1:0];

  // channel state store and forwarding
  logic [DEPTH-1:0]   vld_q;
  logic               rd_vld_q;
  logic               fwd_q;
  chan_state_t        fwd_st_q;
  logic [STATE_W-1:0] rdata;
  chan_state_t        ram_st, cur_st, nxt_st;
  event_t             evt;
  logic               we, hit;

  assign we = s1_valid_q && s1_adv;

  nsd_ram #(
    .WIDTH (STATE_W),
    .DEPTH (DEPTH)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_addr),
    .wdata_i (nxt_st),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    ram_st = chan_state_t'(rdata);
    if (fwd_q) begin
      cur_st = fwd_st_q;
    end else if (rd_vld_q) begin
      cur_st = ram_st;
    end else begin
      // never written: counters and mode at reset, samples unused
      cur_st       = '0;
      cur_st.older = ram_st.older;
      cur_st.newer = ram_st.newer;
    end
  end

  nsd_energy u_energy (
    .prev_i      (cur_st.older),
    .cur_i       (cur_st.newer),
    .next_i      (code_q),
    .threshold_i (thr_q),
    .hit_o       (hit)
  );

  nsd_track u_track (
    .state_i         (cur_st),
    .code_i          (code_q),
    .sample_number_i (idx_q),
    .hit_i           (hit),
    .timeout_i       (tmo_q),
    .onset_i         (ons_q),
    .state_o         (nxt_st),
    .event_o         (evt)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = in_range;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q && evt.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (we) begin
        vld_q[s1_addr] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_q <= vld_q[rd_addr];
        // same channel back to back: the RAM still holds the older word
        fwd_q    <= we && (s1_addr == rd_addr);
      end
    end
  end

  logic              ev_kind_q;
  logic [CHAN_W-1:0] ev_chan_q;
  logic [IDX_W-1:0]  ev_sample_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      code_q   <= adc_sample_i;
      chan_q   <= channel_i;
      idx_q    <= sample_number_i;
      fwd_st_q <= nxt_st;
    end
    if (s1_adv) begin
      ev_kind_q   <= evt.kind;
      ev_chan_q   <= chan_q;
      ev_sample_q <= evt.sample;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = ev_kind_q;
  assign event_channel_o = ev_chan_q;
  assign event_sample_o  = ev_sample_q;

endmodule

FILE: tb/sv/neo_seizure_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neo_seizure_detector_tb
// Self-checking bench for the per-channel energy seizure detector: a queue-fed
// sample driver, a checking monitor on the event stream and an in-bench
// predictor that mirrors each channel's history, counters and mode.
// ----------------------------------------------------------------------------
module neo_seizure_detector_tb;
  import nsd_pkg::*;

  localparam int unsigned NCH           = NUM_CHANNELS_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 300;
  localparam longint      MID_CODE      = 32768;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CHAN_W-1:0] chan;
    logic [IDX_W-1:0]  index;
  } sample_beat_t;

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] chan;
    logic [IDX_W-1:0]  at_sample;
  } seizure_event_t;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic [CODE_W-1:0]     adc_sample_i    = '0;
  logic [CHAN_W-1:0]     channel_i       = '0;
  logic [IDX_W-1:0]      sample_number_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic                  event_kind_o;
  logic [CHAN_W-1:0]     event_channel_o;
  logic [IDX_W-1:0]      event_sample_o;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  neo_seizure_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .adc_sample_i   (adc_sample_i),
    .channel_i      (channel_i),
    .sample_number_i(sample_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .event_channel_o(event_channel_o),
    .event_sample_o (event_sample_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // predictor copy of the registers and of every channel
  logic [THR_W-1:0]  thr_cfg = THR_RESET;
  logic [TMO_W-1:0]  tmo_cfg = TMO_RESET;
  logic [ONS_W-1:0]  ons_cfg = ONS_RESET;
  logic [CODE_W-1:0] older_code [NCH] = '{default: '0};
  logic [CODE_W-1:0] newer_code [NCH] = '{default: '0};
  logic [FILL_W-1:0] codes_seen [NCH] = '{default: '0};
  logic              seizing    [NCH] = '{default: 1'b0};
  logic [ONS_W-1:0]  hit_streak [NCH] = '{default: '0};
  logic [TMO_W-1:0]  quiet_run  [NCH] = '{default: '0};

  sample_beat_t   sample_q [$];
  seizure_event_t pending_events [$];
  sample_beat_t   next_beat;
  seizure_event_t want;

  // stimulus shaping: each channel alternates loud and quiet stretches
  bit             loud_now [MAX_CHANNELS];
  int unsigned    run_left [MAX_CHANNELS];
  logic [IDX_W-1:0] next_index = '0;

  int unsigned queued_count   = 0;
  int unsigned taken_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned starts_seen    = 0;
  int unsigned ends_seen      = 0;
  int unsigned settings_count = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  bit          squeeze_done   = 1'b0;
  logic        idle_on        = 1'b1;
  logic        squeeze_req    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d of %0d samples taken, %0d events outstanding",
             taken_count, queued_count, pending_events.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $realtime, what);
    mismatch_count++;
  endtask

  // advance one channel by one code; queue the event it raises, if any
  function automatic void predict_beat(input logic [CODE_W-1:0] code,
                                       input logic [CHAN_W-1:0] ch,
                                       input logic [IDX_W-1:0]  idx);
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    longint            pa;
    longint            pb;
    longint            pc;
    longint            energy;
    logic              hit;
    int unsigned       onset;
    seizure_event_t    ev;
    onset = (ons_cfg == '0) ? 1 : ons_cfg;
    if (ch >= NCH) return;
    a = older_code[ch];
    b = newer_code[ch];
    older_code[ch] = b;
    newer_code[ch] = code;
    if (codes_seen[ch] < NEEDED_CODES) codes_seen[ch]++;
    if (codes_seen[ch] < NEEDED_CODES) return;
    pa = longint'(a) - MID_CODE;
    pb = longint'(b) - MID_CODE;
    pc = longint'(code) - MID_CODE;
    energy = pb * pb - pa * pc;
    if (energy < 0) energy = -energy;
    hit = energy > longint'({32'd0, thr_cfg});
    ev.chan = ch;
    if (!seizing[ch]) begin
      if (!hit) begin
        hit_streak[ch] = '0;
        return;
      end
      quiet_run[ch] = '0;
      if (32'(hit_streak[ch]) + 32'd1 >= onset) begin
        hit_streak[ch] = '0;
        seizing[ch] = 1'b1;
        ev.kind = KIND_START;
        ev.at_sample = idx - IDX_W'(onset - 1);
        pending_events.insert(pending_events.size(), ev);
      end else begin
        hit_streak[ch]++;
      end
      return;
    end
    if (hit) begin
      quiet_run[ch] = '0;
      return;
    end
    if (32'(quiet_run[ch]) + 32'd1 >= 32'(tmo_cfg)) begin
      quiet_run[ch] = '0;
      seizing[ch] = 1'b0;
      ev.kind = KIND_END;
      ev.at_sample = idx - IDX_W'(tmo_cfg);
      pending_events.insert(pending_events.size(), ev);
    end else begin
      quiet_run[ch]++;
    end
  endfunction

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_beat(adc_sample_i, channel_i, sample_number_i);
        taken_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          next_beat = sample_q.pop_front();
          in_valid_i      <= 1'b1;
          adc_sample_i    <= next_beat.code;
          channel_i       <= next_beat.chan;
          sample_number_i <= next_beat.index;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // event monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("event kind %0d ch %0d at %0d with nothing expected",
                                    event_kind_o, event_channel_o, event_sample_o));
        end else begin
          want = pending_events.pop_front();
          if (event_kind_o !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d (ch %0d)",
                                      event_kind_o, want.kind, want.chan));
          if (event_channel_o !== want.chan)
            report_mismatch($sformatf("channel %0d, expected %0d",
                                      event_channel_o, want.chan));
          if (event_sample_o !== want.at_sample)
            report_mismatch($sformatf("sample %0h, expected %0h (ch %0d)",
                                      event_sample_o, want.at_sample, want.chan));
          if (want.kind == KIND_START) starts_seen++;
          else ends_seen++;
        end
      end
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    unique case (idx)
      CFG_THRESHOLD: thr_cfg = data[THR_W-1:0];
      CFG_TIMEOUT:   tmo_cfg = data[TMO_W-1:0];
      CFG_ONSET:     ons_cfg = data[ONS_W-1:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry junk on purpose
  task automatic set_detector(input logic [THR_W-1:0] thr,
                              input logic [TMO_W-1:0] tmo,
                              input logic [ONS_W-1:0] ons);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_TIMEOUT, {16'($urandom), tmo});
    write_reg(CFG_ONSET, {24'($urandom), ons});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  task automatic push_beat(input logic [CODE_W-1:0] code, input logic [CHAN_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    sample_beat_t beat;
    beat.code  = code;
    beat.chan  = ch;
    beat.index = idx;
    sample_q.insert(sample_q.size(), beat);
    queued_count++;
  endtask

  task automatic queue_samples(input int unsigned count, input int unsigned n_active,
                               input int unsigned span);
    int unsigned  pick [$];
    int unsigned  k;
    int unsigned  ch;
    int unsigned  ons_eff;
    int unsigned  quiet_max;
    sample_beat_t beat;
    ons_eff   = (ons_cfg == '0) ? 1 : ons_cfg;
    quiet_max = ((tmo_cfg > 30) ? 30 : tmo_cfg) + 2;
    for (k = 0; k < n_active; k++)
      pick.insert(pick.size(), $urandom_range(0, MAX_CHANNELS - 1));
    for (k = 0; k < count; k++) begin
      ch = pick[$urandom_range(0, n_active - 1)];
      if (run_left[ch] == 0) begin
        loud_now[ch] = !loud_now[ch];
        if (!loud_now[ch]) run_left[ch] = $urandom_range(1, quiet_max);
        else if ($urandom_range(0, 1) == 1) run_left[ch] = $urandom_range(ons_eff, ons_eff + 2);
        else run_left[ch] = $urandom_range(1, ons_eff);
      end
      run_left[ch]--;
      beat.chan  = CHAN_W'(ch);
      beat.code  = loud_now[ch] ? 16'($urandom)
                                : 16'(32'd32768 + $urandom_range(0, 2 * span) - span);
      beat.index = next_index;
      next_index++;
      // occasional stray beat on any channel with any index
      if ($urandom_range(0, 9) == 0) begin
        beat.chan  = CHAN_W'($urandom);
        beat.code  = CODE_W'($urandom);
        beat.index = IDX_W'({$urandom, $urandom});
      end
      sample_q.insert(sample_q.size(), beat);
      queued_count++;
    end
  endtask

  task automatic wait_idle();
    while (taken_count != queued_count || pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: onset of zero, timeout of zero, extreme codes and indices
    write_reg(CFG_SPARE, $urandom);
    set_detector(32'd100, 16'd0, 8'd0);
    push_beat(16'h0000, 6'd0, 48'd0);
    push_beat(16'hFFFF, 6'd0, 48'd1);
    push_beat(16'h0000, 6'd0, 48'd2);
    push_beat(16'h8000, 6'd0, 48'd3);
    push_beat(16'h8000, 6'd0, 48'd4);
    push_beat(16'hFFFF, 6'd63, 48'hFFFF_FFFF_FFFF);
    push_beat(16'hFFFF, 6'd63, 48'd0);
    push_beat(16'hFFFF, 6'd63, 48'd1);
    push_beat(16'h0000, 6'd63, 48'd2);
    push_beat(16'h5555, 6'd42, 48'hAAAA_AAAA_AAAA);
    push_beat(16'hAAAA, 6'd42, 48'h5555_5555_5555);
    push_beat(16'h7FFF, 6'd42, 48'hAAAA_AAAA_AAAB);
    push_beat(16'h8001, 6'd21, 48'h5555_5555_5556);
    push_beat(16'h0001, 6'd21, 48'hFFFF_FFFF_FFFE);
    push_beat(16'hFFFE, 6'd21, 48'h8000_0000_0000);
    wait_idle();

    // mid settings, with a sender pause halfway
    set_detector(32'd2000, 16'd5, 8'd3);
    next_index = '0;
    queue_samples(180, 4, 15);
    wait_idle();
    queue_samples(180, 4, 15);
    wait_idle();

    // every hit starts, every miss ends; receiver holds off meanwhile
    set_detector(32'd5000, 16'd0, 8'd1);
    squeeze_req <= 1'b1;
    next_index = IDX_W'({$urandom, $urandom});
    queue_samples(250, 6, 15);
    wait_idle();

    // longest onset with zero threshold, index close to wrapping
    set_detector(32'd0, 16'd2, 8'd255);
    next_index = 48'hFFFF_FFFF_FF00;
    queue_samples(400, 1, 0);
    wait_idle();

    // nothing can hit; longest timeout
    set_detector(32'hFFFF_FFFF, 16'hFFFF, 8'd0);
    queue_samples(100, 8, 15);
    wait_idle();

    set_detector(THR_RESET, 16'd1, 8'd2);
    next_index = 48'd3;
    queue_samples(200, 3, 15);
    wait_idle();

    // final stretch with no idling on either side
    idle_on <= 1'b0;
    set_detector(32'd20000, 16'd7, 8'd2);
    next_index = IDX_W'({$urandom, $urandom});
    queue_samples(250, 12, 15);
    wait_idle();

    $display("covered %0d samples over %0d register settings: %0d onsets, %0d ends checked",
             taken_count, settings_count, starts_seen, ends_seen);
    $display("included a %0d-cycle receiver hold-off and a drained sender pause",
             LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
